>>> hdl/efcr_pkg.sv
// ----------------------------------------------------------------------------
// efcr_pkg
// Shared types and constants for the escaped frame CRC receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efcr_pkg;

  localparam int unsigned HeaderBytes = 8;

  localparam int unsigned MidDepth = 4;
  localparam int unsigned MidAw    = $clog2(MidDepth);
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutAw    = $clog2(OutDepth);

  localparam logic [7:0] StartReset     = 8'h73;
  localparam logic [7:0] EscapeReset    = 8'h78;
  localparam logic [7:0] CodeEscReset   = 8'h55;
  localparam logic [7:0] CodeStartReset = 8'h31;

  localparam logic [1:0] RegStart     = 2'd0;
  localparam logic [1:0] RegEscape    = 2'd1;
  localparam logic [1:0] RegCodeEsc   = 2'd2;
  localparam logic [1:0] RegCodeStart = 2'd3;

  typedef struct packed {
    logic [7:0] start_value;
    logic [7:0] escape_value;
    logic [7:0] code_for_escape;
    logic [7:0] code_for_start;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  typedef enum logic {
    TK_HDR = 1'b0,
    TK_PAY = 1'b1
  } tok_cls_e;

  typedef struct packed {
    tok_cls_e   cls;
    logic [2:0] hpos;
    logic [7:0] data;
    logic       bad;
    logic       last;
  } token_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] payload_length;
    logic [7:0]  version;
    logic [15:0] sequence_res;
    logic [7:0]  command;
    logic        crc_ok;
    logic        length_error;
    logic        escape_error;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/efcr_front.sv
// ----------------------------------------------------------------------------
// efcr_front
// Unescapes link bytes, tracks frame phase and length, emits classified tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efcr_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  wire [7:0]            rx_byte_i,
  input  efcr_pkg::cfg_t       cfg_i,
  output logic                 tok_valid_o,
  output efcr_pkg::token_t     tok_o
);
  import efcr_pkg::*;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [2:0]  hpos_q, hpos_d;
  logic [15:0] len_q, len_d;
  logic [15:0] left_q, left_d;

  logic        restart;
  logic        have_v;
  logic        bad;
  logic [7:0]  v;
  logic [15:0] left_dec;

  always_comb begin
    phase_d     = phase_q;
    esc_d       = esc_q;
    hpos_d      = hpos_q;
    len_d       = len_q;
    left_d      = left_q;
    restart     = 1'b0;
    have_v      = 1'b0;
    bad         = 1'b0;
    v           = rx_byte_i;
    left_dec    = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
    tok_valid_o = 1'b0;
    tok_o       = '0;

    if (accept_i) begin
      unique case (phase_q)
        PH_HEADER, PH_PAYLOAD: begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (rx_byte_i == cfg_i.code_for_escape) begin
              v      = cfg_i.escape_value;
              have_v = 1'b1;
            end else if (rx_byte_i == cfg_i.code_for_start) begin
              v      = cfg_i.start_value;
              have_v = 1'b1;
            end else if (rx_byte_i == cfg_i.start_value) begin
              restart = 1'b1;
            end else begin
              bad    = 1'b1;
              have_v = 1'b1;
            end
          end else if (rx_byte_i == cfg_i.start_value) begin
            restart = 1'b1;
          end else if (rx_byte_i == cfg_i.escape_value) begin
            esc_d = 1'b1;
          end else begin
            have_v = 1'b1;
          end
        end
        default: begin
          phase_d = PH_HUNT;
          if (rx_byte_i == cfg_i.start_value) restart = 1'b1;
        end
      endcase

      if (restart) begin
        phase_d = PH_HEADER;
        hpos_d  = 3'd0;
        esc_d   = 1'b0;
        len_d   = 16'd0;
        left_d  = 16'd0;
      end else if (have_v) begin
        tok_valid_o = 1'b1;
        tok_o.data  = v;
        tok_o.bad   = bad;
        tok_o.hpos  = hpos_q;
        if (phase_q == PH_HEADER) begin
          tok_o.cls = TK_HDR;
          if (hpos_q == 3'd0) len_d[7:0] = v;
          if (hpos_q == 3'd1) len_d[15:8] = v;
          if (hpos_q == 3'd7) begin
            hpos_d = 3'd0;
            if (len_q <= 16'(HeaderBytes)) begin
              tok_o.last = 1'b1;
              phase_d    = PH_HUNT;
            end else begin
              left_d  = len_q - 16'(HeaderBytes);
              phase_d = PH_PAYLOAD;
            end
          end else begin
            hpos_d = hpos_q + 3'd1;
          end
        end else begin
          tok_o.cls = TK_PAY;
          left_d    = left_dec;
          if (left_dec == 16'd0) begin
            tok_o.last = 1'b1;
            phase_d    = PH_HUNT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      esc_q   <= 1'b0;
      hpos_q  <= 3'd0;
      len_q   <= 16'd0;
      left_q  <= 16'd0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      hpos_q  <= hpos_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/efcr_queue.sv
// ----------------------------------------------------------------------------
// efcr_queue
// Short token queue between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efcr_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  wr_i,
  input  efcr_pkg::token_t     wr_data_i,
  input  wire                  rd_i,
  output efcr_pkg::token_t     rd_data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import efcr_pkg::*;

  token_t            mem_q [MidDepth];
  logic [MidAw-1:0]  wptr_q, rptr_q;
  logic [MidAw:0]    cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == (MidAw+1)'(MidDepth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + (MidAw+1)'(do_wr) - (MidAw+1)'(do_rd);
    end
  end

endmodule

`default_nettype wire

>>> hdl/efcr_back.sv
// ----------------------------------------------------------------------------
// efcr_back
// Collects header fields, runs the CRC and queues payload and status results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efcr_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  efcr_pkg::token_t     tok_i,
  input  wire                  tok_empty_i,
  output logic                 tok_pop_o,
  input  wire                  pop,
  output logic                 empty,
  output efcr_pkg::res_t       res_o
);
  import efcr_pkg::*;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    end
    return r;
  endfunction

  logic [15:0] crc_q, crc_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic        bad_q, bad_d;

  res_t              mem_q [OutDepth];
  logic [OutAw-1:0]  wptr_q, rptr_q;
  logic [OutAw:0]    cnt_q;

  logic        first;
  logic [15:0] crc_base, crc_next;
  logic        len_err;
  logic [15:0] pay_len;
  logic [1:0]  n_wr;
  res_t        wr0, wr1, pay_res, stat_res;
  logic        pop_fire;

  assign tok_pop_o = !tok_empty_i && (cnt_q <= (OutAw+1)'(OutDepth - 2));
  assign first     = (tok_i.cls == TK_HDR) && (tok_i.hpos == 3'd0);
  assign crc_base  = first ? 16'd0 : crc_q;
  assign crc_next  = crc_byte(crc_base, tok_i.data);
  assign len_err   = len_q < 16'(HeaderBytes);
  assign pay_len   = len_err ? 16'd0 : len_q - 16'(HeaderBytes);

  always_comb begin
    crc_d  = crc_q;
    len_d  = len_q;
    ver_d  = ver_q;
    seq_d  = seq_q;
    cmd_d  = cmd_q;
    rcrc_d = rcrc_q;
    bad_d  = bad_q;
    n_wr   = 2'd0;

    pay_res                = '0;
    pay_res.data_byte      = tok_i.data;
    pay_res.payload_length = pay_len;
    pay_res.version        = ver_q;
    pay_res.sequence_res   = seq_q;
    pay_res.command        = cmd_q;

    stat_res                = '0;
    stat_res.kind           = 1'b1;
    stat_res.last           = 1'b1;
    stat_res.payload_length = pay_len;
    stat_res.version        = ver_q;
    stat_res.sequence_res   = seq_q;
    stat_res.command        = cmd_q;
    stat_res.length_error   = len_err;
    stat_res.escape_error   = bad_q | tok_i.bad;
    stat_res.crc_ok         = (crc_next == rcrc_q);

    wr0 = pay_res;
    wr1 = stat_res;

    if (tok_pop_o) begin
      bad_d = (first ? 1'b0 : bad_q) | tok_i.bad;
      if (tok_i.cls == TK_HDR) begin
        if (tok_i.hpos < 3'd6) crc_d = crc_next;
        case (tok_i.hpos)
          3'd0:    len_d  = {8'h00, tok_i.data};
          3'd1:    len_d  = {tok_i.data, len_q[7:0]};
          3'd2:    ver_d  = tok_i.data;
          3'd3:    seq_d  = {seq_q[15:8], tok_i.data};
          3'd4:    seq_d  = {tok_i.data, seq_q[7:0]};
          3'd5:    cmd_d  = tok_i.data;
          3'd6:    rcrc_d = {rcrc_q[15:8], tok_i.data};
          default: rcrc_d = {tok_i.data, rcrc_q[7:0]};
        endcase
        if (tok_i.last) begin
          wr0              = stat_res;
          wr0.crc_ok       = (crc_q == {tok_i.data, rcrc_q[7:0]});
          wr0.escape_error = bad_d;
          n_wr             = 2'd1;
        end
      end else begin
        crc_d = crc_next;
        n_wr  = tok_i.last ? 2'd2 : 2'd1;
      end
    end
  end

  assign pop_fire = pop && !empty;
  assign empty    = (cnt_q == '0);
  assign res_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) mem_q[wptr_q] <= wr0;
    if (n_wr == 2'd2) mem_q[wptr_q + 1'b1] <= wr1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= 16'd0;
      len_q  <= 16'd0;
      ver_q  <= 8'd0;
      seq_q  <= 16'd0;
      cmd_q  <= 8'd0;
      rcrc_q <= 16'd0;
      bad_q  <= 1'b0;
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      crc_q  <= crc_d;
      len_q  <= len_d;
      ver_q  <= ver_d;
      seq_q  <= seq_d;
      cmd_q  <= cmd_d;
      rcrc_q <= rcrc_d;
      bad_q  <= bad_d;
      wptr_q <= wptr_q + OutAw'(n_wr);
      if (pop_fire) rptr_q <= rptr_q + 1'b1;
      cnt_q  <= cnt_q + (OutAw+1)'(n_wr) - (OutAw+1)'(pop_fire);
    end
  end

endmodule

`default_nettype wire

>>> hdl/escaped_frame_crc_receiver.sv
// ----------------------------------------------------------------------------
// escaped_frame_crc_receiver
// Byte-stuffed frame receiver with header decode and CRC-16 check.
//
// Input channel: drive rx_byte_i with push high; the byte is taken at a clock
// edge where push is high and full is low. One byte per cycle is sustained
// while full stays low. Result channel: while empty is low the oldest result
// sits on the result ports; it is taken at an edge where pop is high. Each
// payload byte gives one result, the end of a frame gives one status result
// (kind 1, last 1). A byte taken is registered in the middle queue and then
// in the result queue before it shows as a result. The front unescapes one
// byte per cycle while full is low; the back takes one token per cycle when
// its result queue has two free slots, so a frame's last payload byte writes
// its byte and status in the same cycle. When the receiver stalls the result
// queue fills, the back holds tokens in the four-entry middle queue and full
// rises once that queue is full. Configuration writes take effect on the next
// edge; write only while idle. Reset returns to start hunting with the
// default start, escape and code values and empties both queues.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_crc_receiver (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  rx_byte_i,
  input  wire         pop,
  output logic        empty,
  output logic        kind_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [15:0] payload_length_o,
  output logic [7:0]  version_o,
  output logic [15:0] sequence_res_o,
  output logic [7:0]  command_o,
  output logic        crc_ok_o,
  output logic        length_error_o,
  output logic        escape_error_o,
  input  wire         cfg_we_i,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [7:0]  cfg_data_i
);
  import efcr_pkg::*;

  cfg_t   cfg_q;
  logic   accept;
  logic   tok_valid;
  token_t tok_in, tok_out;
  logic   mid_empty, mid_pop;
  res_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_value     <= StartReset;
      cfg_q.escape_value    <= EscapeReset;
      cfg_q.code_for_escape <= CodeEscReset;
      cfg_q.code_for_start  <= CodeStartReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegStart:     cfg_q.start_value     <= cfg_data_i;
        RegEscape:    cfg_q.escape_value    <= cfg_data_i;
        RegCodeEsc:   cfg_q.code_for_escape <= cfg_data_i;
        RegCodeStart: cfg_q.code_for_start  <= cfg_data_i;
        default:      cfg_q                 <= cfg_q;
      endcase
    end
  end

  assign accept = push && !full;

  efcr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .tok_valid_o (tok_valid),
    .tok_o       (tok_in)
  );

  efcr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tok_valid),
    .wr_data_i (tok_in),
    .rd_i      (mid_pop),
    .rd_data_o (tok_out),
    .full_o    (full),
    .empty_o   (mid_empty)
  );

  efcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_out),
    .tok_empty_i (mid_empty),
    .tok_pop_o   (mid_pop),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign data_byte_o      = res.data_byte;
  assign last_o           = res.last;
  assign payload_length_o = res.payload_length;
  assign version_o        = res.version;
  assign sequence_res_o   = res.sequence_res;
  assign command_o        = res.command;
  assign crc_ok_o         = res.crc_ok;
  assign length_error_o   = res.length_error;
  assign escape_error_o   = res.escape_error;

  a_mid_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && mid_empty))
    else $error("middle queue reports full and empty");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o) |-> (last_o && data_byte_o == 8'd0))
    else $error("status request malformed");

  a_payload_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !kind_o) |-> (!last_o && !crc_ok_o && !length_error_o && !escape_error_o))
    else $error("payload request carries status flags");

  a_back_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back pops an empty middle queue");

endmodule

`default_nettype wire
